>>> rtl/token_lexer_top_defines.svh
// assertion macros used by the lexer checker file
// expects signals named clock and reset in the scope of use
`ifndef TOKEN_LEXER_TOP_DEFINES_SVH
`define TOKEN_LEXER_TOP_DEFINES_SVH

// property checked only outside reset
`define TLEX_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked at every edge, reset included
`define TLEX_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

>>> rtl/tlex_pkg.sv
// shared constants, codes, structs and keyword tables of the token lexer
// no dependencies
package tlex_pkg;

   // word buffer sizing
   localparam int MAX_WORD    = 32;
   localparam int IDX_W       = (MAX_WORD > 1) ? $clog2(MAX_WORD) : 1;
   localparam int LEN_W       = $clog2(MAX_WORD + 1);
   localparam int KW_COUNT    = 4;
   localparam int KW_MAX_LEN  = 4;

   // field widths
   localparam int CH_W   = 8;
   localparam int KIND_W = 3;
   localparam int OP_W   = 4;
   localparam int KW_W   = 2;
   localparam int NUM_W  = 32;

   // token kinds
   localparam logic [KIND_W-1:0] KIND_NEWLINE  = 3'd0;
   localparam logic [KIND_W-1:0] KIND_OPERATOR = 3'd1;
   localparam logic [KIND_W-1:0] KIND_NUMBER   = 3'd2;
   localparam logic [KIND_W-1:0] KIND_KEYWORD  = 3'd3;
   localparam logic [KIND_W-1:0] KIND_IDENT    = 3'd4;
   localparam logic [KIND_W-1:0] KIND_ERROR    = 3'd5;
   localparam logic [KIND_W-1:0] KIND_END      = 3'd6;

   // operator codes
   localparam logic [OP_W-1:0] OP_ADD        = 4'd0;
   localparam logic [OP_W-1:0] OP_SUB        = 4'd1;
   localparam logic [OP_W-1:0] OP_MUL        = 4'd2;
   localparam logic [OP_W-1:0] OP_DIV        = 4'd3;
   localparam logic [OP_W-1:0] OP_ASSIGN     = 4'd4;
   localparam logic [OP_W-1:0] OP_EQUAL      = 4'd5;
   localparam logic [OP_W-1:0] OP_GREATER    = 4'd6;
   localparam logic [OP_W-1:0] OP_GREATER_EQ = 4'd7;
   localparam logic [OP_W-1:0] OP_LESS       = 4'd8;
   localparam logic [OP_W-1:0] OP_LESS_EQ    = 4'd9;

   // keyword codes
   localparam logic [KW_W-1:0] KW_IF   = 2'd0;
   localparam logic [KW_W-1:0] KW_THEN = 2'd1;
   localparam logic [KW_W-1:0] KW_ELSE = 2'd2;
   localparam logic [KW_W-1:0] KW_END  = 2'd3;

   // error codes
   localparam logic ERR_DIGIT_LETTER = 1'b0;
   localparam logic ERR_TOO_LONG     = 1'b1;

   // waiting compare operator
   localparam logic [1:0] PEND_NONE    = 2'd0;
   localparam logic [1:0] PEND_ASSIGN  = 2'd1;
   localparam logic [1:0] PEND_GREATER = 2'd2;
   localparam logic [1:0] PEND_LESS    = 2'd3;

   // character codes
   localparam logic [CH_W-1:0] CH_NUL     = 8'h00;
   localparam logic [CH_W-1:0] CH_TAB     = 8'h09;
   localparam logic [CH_W-1:0] CH_NL      = 8'h0A;
   localparam logic [CH_W-1:0] CH_SPACE   = 8'h20;
   localparam logic [CH_W-1:0] CH_STAR    = 8'h2A;
   localparam logic [CH_W-1:0] CH_PLUS    = 8'h2B;
   localparam logic [CH_W-1:0] CH_MINUS   = 8'h2D;
   localparam logic [CH_W-1:0] CH_SLASH   = 8'h2F;
   localparam logic [CH_W-1:0] CH_ZERO    = 8'h30;
   localparam logic [CH_W-1:0] CH_NINE    = 8'h39;
   localparam logic [CH_W-1:0] CH_LESS    = 8'h3C;
   localparam logic [CH_W-1:0] CH_EQUAL   = 8'h3D;
   localparam logic [CH_W-1:0] CH_GREATER = 8'h3E;
   localparam logic [CH_W-1:0] CH_UPPER_A = 8'h41;
   localparam logic [CH_W-1:0] CH_UPPER_Z = 8'h5A;
   localparam logic [CH_W-1:0] CH_LOWER_A = 8'h61;
   localparam logic [CH_W-1:0] CH_LOWER_Z = 8'h7A;

   // controller states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_CMP,
      ST_WORD,
      ST_IDENT,
      ST_TAIL
   } state_type;

   // one result beat
   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [OP_W-1:0]   op_code;
      logic [KW_W-1:0]   keyword_code;
      logic [NUM_W-1:0]  number_value;
      logic [CH_W-1:0]   ident_char;
      logic              error_code;
      logic              last;
   } rsp_item_type;

   // controller to datapath
   typedef struct packed {
      logic accept;
      logic emit_cmp;
      logic emit_word;
      logic rd_start;
      logic emit_char;
      logic emit_tail;
      logic clear_word;
      logic last;
   } ctrl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic has_cmp;
      logic has_word;
      logic has_tail;
      logic word_is_ident;
      logic ident_last;
      logic out_free;
   } dp_status_type;

   // keyword spelling, one character per position
   function automatic logic [CH_W-1:0] kw_char(input logic [1:0] k, input logic [1:0] p);
      logic [CH_W-1:0] c;
      case ({k, p})
         4'b00_00: c = 8'h69;  // i
         4'b00_01: c = 8'h66;  // f
         4'b01_00: c = 8'h74;  // t
         4'b01_01: c = 8'h68;  // h
         4'b01_10: c = 8'h65;  // e
         4'b01_11: c = 8'h6E;  // n
         4'b10_00: c = 8'h65;  // e
         4'b10_01: c = 8'h6C;  // l
         4'b10_10: c = 8'h73;  // s
         4'b10_11: c = 8'h65;  // e
         4'b11_00: c = 8'h65;  // e
         4'b11_01: c = 8'h6E;  // n
         4'b11_10: c = 8'h64;  // d
         default:  c = 8'h00;  // past the end of a short keyword
      endcase
      return c;
   endfunction

   // keyword lengths
   function automatic logic [2:0] kw_len(input logic [1:0] k);
      logic [2:0] n;
      case (k)
         KW_IF:   n = 3'd2;
         KW_THEN: n = 3'd4;
         KW_ELSE: n = 3'd4;
         KW_END:  n = 3'd3;
         default: n = 3'd0;
      endcase
      return n;
   endfunction

endpackage

>>> rtl/tlex_req_if.sv
// character channel: valid, ready and one source byte with end of text flag
// depends on tlex_pkg
interface tlex_req_if;
   import tlex_pkg::*;

   logic            valid;
   logic            ready;
   logic [CH_W-1:0] ch;
   logic            end_of_text;

   modport source  (output valid, output ch, output end_of_text, input ready);
   modport sink    (input valid, input ch, input end_of_text, output ready);
   modport monitor (input valid, input ch, input end_of_text, input ready);
endinterface

>>> rtl/tlex_rsp_if.sv
// token channel: valid, ready and the token fields
// depends on tlex_pkg
interface tlex_rsp_if;
   import tlex_pkg::*;

   logic              valid;
   logic              ready;
   logic [KIND_W-1:0] kind;
   logic [OP_W-1:0]   op_code;
   logic [KW_W-1:0]   keyword_code;
   logic [NUM_W-1:0]  number_value;
   logic [CH_W-1:0]   ident_char;
   logic              error_code;
   logic              last;

   modport source (
      output valid, output kind, output op_code, output keyword_code,
      output number_value, output ident_char, output error_code, output last,
      input ready
   );
   modport sink (
      input valid, input kind, input op_code, input keyword_code,
      input number_value, input ident_char, input error_code, input last,
      output ready
   );
   modport monitor (
      input valid, input kind, input op_code, input keyword_code,
      input number_value, input ident_char, input error_code, input last,
      input ready
   );
endinterface

>>> rtl/tlex_ctrl.sv
// lexer controller: accepts a character and sequences the tokens it completes
// depends on tlex_pkg
module tlex_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tlex_pkg::dp_status_type status,
   output tlex_pkg::ctrl_cmd_type  cmd
);
   import tlex_pkg::*;

   state_type state_ff, state_in;
   logic      word_ff, word_in;
   logic      tail_ff, tail_in;

   // state and plan registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         word_ff  <= 1'b0;
         tail_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         word_ff  <= word_in;
         tail_ff  <= tail_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      word_in   = word_ff;
      tail_in   = tail_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.accept = 1'b1;
               word_in    = status.has_word;
               tail_in    = status.has_tail;
               if (status.has_cmp) begin
                  state_in = ST_CMP;
               end else if (status.has_word) begin
                  state_in = ST_WORD;
               end else if (status.has_tail) begin
                  state_in = ST_TAIL;
               end
            end
         end
         ST_CMP: begin
            if (status.out_free) begin
               cmd.emit_cmp = 1'b1;
               cmd.last     = !word_ff && !tail_ff;
               if (word_ff) begin
                  state_in = ST_WORD;
               end else if (tail_ff) begin
                  state_in = ST_TAIL;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_WORD: begin
            if (status.word_is_ident) begin
               // first store read, characters follow
               cmd.rd_start = 1'b1;
               state_in     = ST_IDENT;
            end else if (status.out_free) begin
               cmd.emit_word  = 1'b1;
               cmd.clear_word = 1'b1;
               cmd.last       = !tail_ff;
               state_in       = tail_ff ? ST_TAIL : ST_IDLE;
            end
         end
         ST_IDENT: begin
            if (status.out_free) begin
               cmd.emit_char = 1'b1;
               cmd.last      = status.ident_last && !tail_ff;
               if (status.ident_last) begin
                  cmd.clear_word = 1'b1;
                  state_in       = tail_ff ? ST_TAIL : ST_IDLE;
               end
            end
         end
         ST_TAIL: begin
            if (status.out_free) begin
               cmd.emit_tail = 1'b1;
               cmd.last      = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/tlex_dp.sv
// lexer datapath: character decode, word state, word store and result register
// depends on tlex_pkg
module tlex_dp (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [tlex_pkg::CH_W-1:0] in_ch,
   input  logic                    in_eot,
   input  tlex_pkg::ctrl_cmd_type  cmd,
   output tlex_pkg::dp_status_type status,
   input  logic                    out_ready,
   output logic                    out_valid,
   output tlex_pkg::rsp_item_type  out_item
);
   import tlex_pkg::*;

   // word store
   logic [CH_W-1:0] store [MAX_WORD];

   // word state
   logic                in_word_ff, in_word_in;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic [NUM_W-1:0]    acc_ff, acc_in;
   logic                sd_ff, sd_in;
   logic                lad_ff, lad_in;
   logic                ovf_ff, ovf_in;
   logic [KW_COUNT-1:0] match_ff, match_in;
   logic [1:0]          pend_ff, pend_in;

   // per-item registers
   logic [OP_W-1:0]   cmp_op_ff;
   logic [KIND_W-1:0] tail_kind_ff;
   logic [OP_W-1:0]   tail_op_ff;

   // identifier readout
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CH_W-1:0]  rd_data_ff;

   // result register
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff, out_item_in;

   // decode
   logic            is_sep, is_dig, is_let, is_nl, is_arith, is_cmp;
   logic [OP_W-1:0] arith_op;
   logic [1:0]      cmp_code;
   logic            has_cmp, cmp_eq, word_end, do_add;
   logic [OP_W-1:0] cmp_base, cmp_op_in;
   logic [KIND_W-1:0] tail_kind_in;
   logic [OP_W-1:0]   tail_op_in;

   // add-character terms
   logic                start;
   logic [LEN_W-1:0]    len_b;
   logic [NUM_W-1:0]    acc_b, acc_add;
   logic                sd_b, lad_b, ovf_b, room;
   logic [KW_COUNT-1:0] match_b, match_add;
   logic [NUM_W+3:0]    prod;

   // word classification
   logic [KW_COUNT-1:0] kw_hit;
   logic [KW_W-1:0]     kw_code;
   logic                word_is_ident;
   rsp_item_type        word_item;
   logic                emit;

   // character classes
   always_comb begin
      is_sep = (in_ch == CH_SPACE) || (in_ch == CH_TAB) || (in_ch == CH_NUL);
      is_dig = (in_ch >= CH_ZERO) && (in_ch <= CH_NINE);
      is_let = ((in_ch >= CH_UPPER_A) && (in_ch <= CH_UPPER_Z)) ||
               ((in_ch >= CH_LOWER_A) && (in_ch <= CH_LOWER_Z));
      is_nl  = (in_ch == CH_NL);
      is_arith = (in_ch == CH_PLUS) || (in_ch == CH_MINUS) ||
                 (in_ch == CH_STAR) || (in_ch == CH_SLASH);
      is_cmp = (in_ch == CH_EQUAL) || (in_ch == CH_GREATER) || (in_ch == CH_LESS);
      case (in_ch)
         CH_PLUS:  arith_op = OP_ADD;
         CH_MINUS: arith_op = OP_SUB;
         CH_STAR:  arith_op = OP_MUL;
         default:  arith_op = OP_DIV;
      endcase
      case (in_ch)
         CH_EQUAL:   cmp_code = PEND_ASSIGN;
         CH_GREATER: cmp_code = PEND_GREATER;
         default:    cmp_code = PEND_LESS;
      endcase
   end

   // plan of the tokens this character completes
   always_comb begin
      has_cmp = (pend_ff != PEND_NONE);
      cmp_eq  = !in_eot && has_cmp && (in_ch == CH_EQUAL);
      case (pend_ff)
         PEND_ASSIGN:  cmp_base = OP_ASSIGN;
         PEND_GREATER: cmp_base = OP_GREATER;
         PEND_LESS:    cmp_base = OP_LESS;
         default:      cmp_base = OP_ADD;
      endcase
      cmp_op_in = cmp_base + {{(OP_W-1){1'b0}}, cmp_eq};
      // an equals sign that completes a compare is used up
      word_end = in_eot || (!cmp_eq && (is_sep || is_nl || is_arith || is_cmp));
      do_add   = !in_eot && (is_dig || is_let);
      if (in_eot) begin
         tail_kind_in = KIND_END;
         tail_op_in   = OP_ADD;
      end else if (is_nl) begin
         tail_kind_in = KIND_NEWLINE;
         tail_op_in   = OP_ADD;
      end else begin
         tail_kind_in = KIND_OPERATOR;
         tail_op_in   = arith_op;
      end
      pend_in = (!in_eot && !cmp_eq && is_cmp) ? cmp_code : PEND_NONE;
   end

   // word update for a letter or digit
   always_comb begin
      start   = !in_word_ff;
      len_b   = start ? '0 : len_ff;
      acc_b   = start ? '0 : acc_ff;
      sd_b    = start ? is_dig : sd_ff;
      lad_b   = start ? 1'b0 : lad_ff;
      ovf_b   = start ? 1'b0 : ovf_ff;
      match_b = start ? '1 : match_ff;
      // value times ten plus the digit, ascii digits carry their value in the low nibble
      prod = ({4'b0000, acc_b} << 3) + ({4'b0000, acc_b} << 1) +
             {{NUM_W{1'b0}}, in_ch[3:0]};
      if (is_dig) begin
         acc_add = (prod[NUM_W+3:NUM_W] != 4'b0000) ? '1 : prod[NUM_W-1:0];
      end else begin
         acc_add = acc_b;
      end
      room = (len_b < LEN_W'(MAX_WORD));
      for (int k = 0; k < KW_COUNT; k++) begin
         match_add[k] = match_b[k] && (len_b < LEN_W'(KW_MAX_LEN)) &&
                        (in_ch == kw_char(2'(k), len_b[1:0]));
      end
   end

   always_comb begin
      in_word_in = in_word_ff;
      len_in     = len_ff;
      acc_in     = acc_ff;
      sd_in      = sd_ff;
      lad_in     = lad_ff;
      ovf_in     = ovf_ff;
      match_in   = match_ff;
      if (cmd.clear_word) begin
         in_word_in = 1'b0;
         len_in     = '0;
         acc_in     = '0;
         sd_in      = 1'b0;
         lad_in     = 1'b0;
         ovf_in     = 1'b0;
         match_in   = '0;
      end else if (cmd.accept && do_add) begin
         in_word_in = 1'b1;
         len_in     = room ? len_b + LEN_W'(1) : len_b;
         acc_in     = acc_add;
         sd_in      = sd_b;
         lad_in     = lad_b || (!is_dig && sd_b);
         ovf_in     = ovf_b || !room;
         match_in   = match_add;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_word_ff <= 1'b0;
         len_ff     <= '0;
         acc_ff     <= '0;
         sd_ff      <= 1'b0;
         lad_ff     <= 1'b0;
         ovf_ff     <= 1'b0;
         match_ff   <= '0;
         pend_ff    <= PEND_NONE;
      end else begin
         in_word_ff <= in_word_in;
         len_ff     <= len_in;
         acc_ff     <= acc_in;
         sd_ff      <= sd_in;
         lad_ff     <= lad_in;
         ovf_ff     <= ovf_in;
         match_ff   <= match_in;
         if (cmd.accept) begin
            pend_ff <= pend_in;
         end
      end
   end

   // tokens waiting behind the accepted character
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         cmp_op_ff    <= cmp_op_in;
         tail_kind_ff <= tail_kind_in;
         tail_op_ff   <= tail_op_in;
      end
   end

   // store write at the current word length
   always_ff @(posedge clock) begin
      if (cmd.accept && do_add && room) begin
         store[len_b[IDX_W-1:0]] <= in_ch;
      end
   end

   // store read, data always follows the read index
   always_comb begin
      if (cmd.rd_start) begin
         idx_in = '0;
      end else if (cmd.emit_char && (idx_ff != IDX_W'(MAX_WORD - 1))) begin
         idx_in = idx_ff + IDX_W'(1);
      end else begin
         idx_in = idx_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      rd_data_ff <= store[idx_in];
   end

   // word classification
   always_comb begin
      for (int k = 0; k < KW_COUNT; k++) begin
         kw_hit[k] = match_ff[k] && (len_ff == LEN_W'(kw_len(2'(k))));
      end
      if (kw_hit[0]) begin
         kw_code = KW_IF;
      end else if (kw_hit[1]) begin
         kw_code = KW_THEN;
      end else if (kw_hit[2]) begin
         kw_code = KW_ELSE;
      end else begin
         kw_code = KW_END;
      end
      word_is_ident = !sd_ff && !ovf_ff && (kw_hit == '0);
      word_item = '0;
      if (sd_ff) begin
         if (lad_ff) begin
            word_item.kind       = KIND_ERROR;
            word_item.error_code = ERR_DIGIT_LETTER;
         end else begin
            word_item.kind         = KIND_NUMBER;
            word_item.number_value = acc_ff;
         end
      end else if (ovf_ff) begin
         word_item.kind       = KIND_ERROR;
         word_item.error_code = ERR_TOO_LONG;
      end else begin
         word_item.kind         = KIND_KEYWORD;
         word_item.keyword_code = kw_code;
      end
   end

   // result register
   always_comb begin
      emit        = cmd.emit_cmp || cmd.emit_word || cmd.emit_char || cmd.emit_tail;
      out_item_in = '0;
      if (cmd.emit_cmp) begin
         out_item_in.kind    = KIND_OPERATOR;
         out_item_in.op_code = cmp_op_ff;
      end else if (cmd.emit_word) begin
         out_item_in = word_item;
      end else if (cmd.emit_char) begin
         out_item_in.kind       = KIND_IDENT;
         out_item_in.ident_char = rd_data_ff;
      end else begin
         out_item_in.kind    = tail_kind_ff;
         out_item_in.op_code = tail_op_ff;
      end
      out_item_in.last = cmd.last;
      if (emit) begin
         out_valid_in = 1'b1;
      end else if (out_ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         out_item_ff <= out_item_in;
      end
   end

   // status to the controller
   always_comb begin
      status.has_cmp       = has_cmp;
      status.has_word      = in_word_ff && word_end;
      status.has_tail      = in_eot || (!cmp_eq && (is_nl || is_arith));
      status.word_is_ident = word_is_ident;
      status.ident_last    = ((LEN_W'(idx_ff) + LEN_W'(1)) == len_ff);
      status.out_free      = !out_valid_ff || out_ready;
   end

   assign out_valid = out_valid_ff;
   assign out_item  = out_item_ff;

endmodule

>>> rtl/token_lexer_top.sv
// token lexer top level: joins controller, datapath and the two channels
// depends on tlex_pkg, tlex_req_if, tlex_rsp_if, tlex_ctrl, tlex_dp
//
//  channel   direction  beat
//  req_bus   in         ch, end_of_text
//  rsp_bus   out        kind, op_code, keyword_code, number_value, ident_char,
//                       error_code, last
//
// a letter, digit or skipped byte is taken in the idle state; each token it completes
// passes through the single result register, an identifier first starts the word
// store read and then emits one beat per character
// characters are taken only while the controller is idle; a stalled result holds
// its beat and the sequence waits on the result register, not on the input side
// synchronous reset clears the word state, the waiting compare and the result valid
module token_lexer_top (
   input logic       clock,
   input logic       reset,
   tlex_req_if.sink   req_bus,
   tlex_rsp_if.source rsp_bus
);
   import tlex_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   rsp_item_type  out_item;
   logic          out_valid;

   // sequencer
   tlex_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // decode, word state and result register
   tlex_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .in_ch     (req_bus.ch),
      .in_eot    (req_bus.end_of_text),
      .cmd       (cmd),
      .status    (status),
      .out_ready (rsp_bus.ready),
      .out_valid (out_valid),
      .out_item  (out_item)
   );

   // result beat onto the channel
   assign rsp_bus.valid        = out_valid;
   assign rsp_bus.kind         = out_item.kind;
   assign rsp_bus.op_code      = out_item.op_code;
   assign rsp_bus.keyword_code = out_item.keyword_code;
   assign rsp_bus.number_value = out_item.number_value;
   assign rsp_bus.ident_char   = out_item.ident_char;
   assign rsp_bus.error_code   = out_item.error_code;
   assign rsp_bus.last         = out_item.last;

endmodule

>>> rtl/tlex_checker.sv
// port-level checks on the token channel, bound to the top level
// depends on tlex_pkg and token_lexer_top_defines.svh
`include "token_lexer_top_defines.svh"

module tlex_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [tlex_pkg::KIND_W-1:0] rsp_kind,
   input logic [tlex_pkg::NUM_W-1:0]  rsp_number_value,
   input logic                        rsp_last
);
   import tlex_pkg::*;

   // fields that must hold while a beat waits
   logic [KIND_W+NUM_W:0] rsp_held;

   assign rsp_held = {rsp_kind, rsp_number_value, rsp_last};

   // no beat offered straight after reset
   `TLEX_ASSERT_RST(a_rst_idle, reset |=> !rsp_valid, "result valid after reset")

   // a stalled beat holds
   `TLEX_ASSERT(a_stall_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_held), "stalled beat changed")

   // end token closes its character
   `TLEX_ASSERT(a_end_last, rsp_valid && (rsp_kind == KIND_END) |-> rsp_last, "end token not last")

   // value field only carries numbers
   `TLEX_ASSERT(a_num_zero, rsp_valid && (rsp_kind != KIND_NUMBER) |-> (rsp_number_value == '0), "value set on non-number")

endmodule

bind token_lexer_top tlex_checker u_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp_bus.valid),
   .rsp_ready        (rsp_bus.ready),
   .rsp_kind         (rsp_bus.kind),
   .rsp_number_value (rsp_bus.number_value),
   .rsp_last         (rsp_bus.last)
);
